FILE: hdl/rfq_pkg.sv
// Shared request codes, defaults and the stage-one operation record.
package rfq_pkg;

	// Default configuration
	localparam int unsigned DEPTH_DEF      = 128;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// Port field widths
	localparam int unsigned REQ_W   = 3;
	localparam int unsigned FIELD_W = 32;
	localparam int unsigned COUNT_W = 8;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_STATUS  = 3'd4;

	// Decoded operation carried from the control stage to the result stage
	typedef struct packed {
		logic               valid;
		logic               ok;
		logic               put;
		logic               take;
		logic               clr;
		logic               flip;
		logic               prev_empty;
		logic               now_empty;
		logic               now_full;
		logic [COUNT_W-1:0] count;
	} rfq_op_t;

endpackage

FILE: hdl/rfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rfq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/rfq_ctrl.sv
// Ring pointer, count and direction state; request decode and RAM addressing.
module rfq_ctrl #(
	parameter int unsigned DEPTH      = rfq_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = rfq_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rfq_pkg::REQ_W-1:0]         req_type,
	input  logic signed [rfq_pkg::FIELD_W-1:0] in_value,
	output logic                              busy,
	output rfq_pkg::rfq_op_t                  op_s1,
	output logic [DATA_WIDTH-1:0]             val_s1,
	output logic                              ram_we,
	output logic [$clog2(DEPTH)-1:0]          ram_waddr,
	output logic [DATA_WIDTH-1:0]             ram_wdata,
	output logic                              ram_re,
	output logic [$clog2(DEPTH)-1:0]          ram_raddr
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [AW-1:0]    ptr_q, ptr_n, ptr_inc, ptr_dec;
	logic [CW-1:0]    count_q, count_n;
	logic             rev_q, rev_n;
	logic             count_zero, count_full;
	rfq_pkg::rfq_op_t op_n;

	// Ring slot at an offset below DEPTH from a base slot
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return AW'(sum);
	endfunction

	assign busy       = 1'b0;
	assign count_zero = (count_q == '0);
	assign count_full = (count_q == CW'(DEPTH));
	assign ptr_inc    = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);
	assign ptr_dec    = (ptr_q == '0) ? AW'(DEPTH - 1) : ptr_q - AW'(1);
	assign ram_wdata  = DATA_WIDTH'(in_value);

	// Decode the request and work out the next state and RAM accesses
	always_comb begin
		ptr_n     = ptr_q;
		count_n   = count_q;
		rev_n     = rev_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = wrap_add(ptr_q, count_q);
		ram_raddr = ptr_inc;
		op_n      = '0;
		op_n.ok   = 1'b1;
		case (req_type)
			rfq_pkg::REQ_INSERT: begin
				if (count_full) begin
					op_n.ok = 1'b0;
				end else begin
					op_n.put = 1'b1;
					ram_we   = start;
					count_n  = count_q + CW'(1);
					if (rev_q) begin
						// logical back is the physical start: grow downward
						ptr_n     = ptr_dec;
						ram_waddr = ptr_dec;
					end
				end
			end
			rfq_pkg::REQ_REMOVE: begin
				if (count_zero) begin
					op_n.ok = 1'b0;
				end else begin
					op_n.take = 1'b1;
					ram_re    = start;
					count_n   = count_q - CW'(1);
					if (!rev_q) begin
						ptr_n = ptr_inc;
					end else if (count_q >= CW'(2)) begin
						// fetch the entry that becomes the logical front
						ram_raddr = wrap_add(ptr_q, count_q - CW'(2));
					end else begin
						ram_raddr = ptr_q;
					end
				end
			end
			rfq_pkg::REQ_CLEAR: begin
				op_n.clr = 1'b1;
				ptr_n    = '0;
				count_n  = '0;
				rev_n    = 1'b0;
			end
			rfq_pkg::REQ_REVERSE: begin
				op_n.flip = 1'b1;
				rev_n     = !rev_q;
			end
			rfq_pkg::REQ_STATUS: begin
			end
			default: begin
			end
		endcase
		op_n.valid      = start;
		op_n.prev_empty = count_zero;
		op_n.now_empty  = (count_n == '0);
		op_n.now_full   = (count_n == CW'(DEPTH));
		op_n.count      = rfq_pkg::COUNT_W'(count_n);
	end

	// Advance the ring state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (start) begin
			ptr_q   <= ptr_n;
			count_q <= count_n;
			rev_q   <= rev_n;
		end
	end

	// Hold the decoded operation for the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op_n;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_s1 <= ram_wdata;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");
	a_remove_empty: assert property (@(posedge clk) disable iff (!arst_n)
		start && count_zero && req_type == rfq_pkg::REQ_REMOVE |=> !op_s1.ok)
		else $error("remove from empty queue not refused");
	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		start && req_type == rfq_pkg::REQ_CLEAR |=> count_q == '0 && ptr_q == '0 && !rev_q)
		else $error("clear left ring state behind");
`endif

endmodule

FILE: hdl/rfq_result.sv
// Result stage: forms front, back and removed values and registers the result.
module rfq_result #(
	parameter int unsigned DATA_WIDTH = rfq_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rfq_pkg::rfq_op_t                   op_s1,
	input  logic [DATA_WIDTH-1:0]              val_s1,
	input  logic [DATA_WIDTH-1:0]              rdata,
	output logic                               done,
	output logic                               ok,
	output logic signed [rfq_pkg::FIELD_W-1:0] removed_value,
	output logic signed [rfq_pkg::FIELD_W-1:0] front_value,
	output logic signed [rfq_pkg::FIELD_W-1:0] back_value,
	output logic [rfq_pkg::COUNT_W-1:0]        entry_count,
	output logic                               is_empty,
	output logic                               is_full
);

	logic                               done_q, ok_q, empty_q, full_q;
	logic signed [rfq_pkg::FIELD_W-1:0] removed_q, front_q, back_q;
	logic signed [rfq_pkg::FIELD_W-1:0] removed_n, front_n, back_n;
	logic signed [rfq_pkg::FIELD_W-1:0] val_ext, rd_ext;
	logic [rfq_pkg::COUNT_W-1:0]        count_q;

	// Sign-extend stored words to the field width
	assign val_ext = rfq_pkg::FIELD_W'($signed(val_s1));
	assign rd_ext  = rfq_pkg::FIELD_W'($signed(rdata));

	// Derive the new end values from the previous ones, the inserted value and the RAM read
	always_comb begin
		removed_n = op_s1.take ? front_q : '0;
		front_n   = front_q;
		back_n    = back_q;
		if (op_s1.now_empty) begin
			front_n = '0;
			back_n  = '0;
		end else if (op_s1.put) begin
			back_n = val_ext;
			if (op_s1.prev_empty) begin
				front_n = val_ext;
			end
		end else if (op_s1.take) begin
			front_n = rd_ext;
		end else if (op_s1.flip) begin
			front_n = back_q;
			back_n  = front_q;
		end
	end

	// Pulse the result strobe once per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= op_s1.valid;
		end
	end

	// Hold the result payload until the next transfer
	always_ff @(posedge clk) begin
		if (op_s1.valid) begin
			ok_q      <= op_s1.ok;
			removed_q <= removed_n;
			front_q   <= front_n;
			back_q    <= back_n;
			count_q   <= op_s1.count;
			empty_q   <= op_s1.now_empty;
			full_q    <= op_s1.now_full;
		end
	end

	assign done          = done_q;
	assign ok            = ok_q;
	assign removed_value = removed_q;
	assign front_value   = front_q;
	assign back_value    = back_q;
	assign entry_count   = count_q;
	assign is_empty      = empty_q;
	assign is_full       = full_q;

`ifndef SYNTHESIS
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_empty && is_full))
		else $error("queue reported both empty and full");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_empty |-> front_value == '0 && back_value == '0 && entry_count == '0)
		else $error("empty queue reported nonzero values");
	a_strobe_follows: assert property (@(posedge clk) disable iff (!arst_n)
		op_s1.valid |=> done)
		else $error("result strobe missing after operation");
`endif

endmodule

FILE: hdl/reversible_fifo_queue_unit.sv
// Top level of the reversible FIFO queue: ring state, entry RAM, result stage.
// Result path: the result strobe done is high for one cycle per request and is
//   set through the request register, then the result register.
// Throughput: one request per clock; busy is never asserted, the entry RAM
//   takes one write and one registered read per cycle.
// Reset: pointer, count, direction and strobe clear at once; entries are not cleared.
module reversible_fifo_queue_unit #(
	parameter int unsigned DEPTH      = rfq_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = rfq_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [rfq_pkg::REQ_W-1:0]          req_type,
	input  logic signed [rfq_pkg::FIELD_W-1:0] in_value,
	output logic                               done,
	output logic                               ok,
	output logic signed [rfq_pkg::FIELD_W-1:0] removed_value,
	output logic signed [rfq_pkg::FIELD_W-1:0] front_value,
	output logic signed [rfq_pkg::FIELD_W-1:0] back_value,
	output logic [rfq_pkg::COUNT_W-1:0]        entry_count,
	output logic                               is_empty,
	output logic                               is_full
);

	localparam int unsigned AW = $clog2(DEPTH);

	rfq_pkg::rfq_op_t      op_s1;
	logic [DATA_WIDTH-1:0] val_s1;
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	// Decode requests and keep the ring state
	rfq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.in_value  (in_value),
		.busy      (busy),
		.op_s1     (op_s1),
		.val_s1    (val_s1),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	// Entry storage
	rfq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Form and register the result
	rfq_result #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_s1         (op_s1),
		.val_s1        (val_s1),
		.rdata         (ram_rdata),
		.done          (done),
		.ok            (ok),
		.removed_value (removed_value),
		.front_value   (front_value),
		.back_value    (back_value),
		.entry_count   (entry_count),
		.is_empty      (is_empty),
		.is_full       (is_full)
	);

endmodule
